### hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared definitions for the positional list engine
// sizes, action and status codes, and the control bundle sent to the cells
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;

	// fixed field widths of the stream payloads
	localparam int ACT_W     = 3;
	localparam int VALUE_W   = 32;
	localparam int POS_W     = 5;
	localparam int STATUS_W  = 2;
	localparam int OUT_CNT_W = 5;
	localparam int REMOVED_W = 32;

	localparam int IN_W  = ACT_W + VALUE_W + POS_W;
	localparam int OUT_W = STATUS_W + OUT_CNT_W + REMOVED_W;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// internal widths
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd4;
	localparam logic [ACT_W-1:0] ACT_DELETE     = 3'd5;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} ple_status_t;

	// broadcast to every cell in the chain
	typedef struct packed {
		logic                  open_gap;
		logic                  close_gap;
		logic [IDX_W-1:0]      at;
		logic [DATA_WIDTH-1:0] fill;
	} ple_ctrl_t;

endpackage

### hw/rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell: one storage cell of the list chain
// holds one entry; takes the new value, its left or right neighbor, or holds
// ----------------------------------------------------------------------------
module ple_cell
	import ple_pkg::*;
(
	input  logic                  clk,
	input  logic [IDX_W-1:0]      idx,
	input  ple_ctrl_t             ctrl,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] tap
);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.open_gap) begin
			if (idx == ctrl.at) begin
				data_q <= ctrl.fill;
			end else if (idx > ctrl.at) begin
				data_q <= left_data;
			end
		end else if (ctrl.close_gap && (idx >= ctrl.at)) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;
	// only the addressed cell drives its entry onto the removal bus
	assign tap  = (idx == ctrl.at) ? data_q : '0;

endmodule

### hw/rtl/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit: ordered list with positional insert and delete
// stream in one action per transfer, stream out one status/count/value result
// ----------------------------------------------------------------------------
// The list lives in a chain of CAPACITY cells; every cell takes its new value
// from itself, its left neighbor, its right neighbor or the pushed value in the
// same clock, so any push, pop, insert or delete updates all cells at once. The
// block accepts one action per cycle while no result is stalled, and its result
// appears on the master side in the cycle after the input transfer, held in a
// single output register. The slave side stays ready while that register is
// empty or being drained in the same cycle, so a downstream stall backs up the
// input only once a result is waiting. Refused actions (full, empty, bad position)
// leave the list as it is. Actions 6 and 7 return ok with the count unchanged.
// Entries need no clearing after reset: only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine_unit
	import ple_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// slave side
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // action[2:0], value[34:3], position[39:35]
	// master side
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // status[1:0], count[6:2], removed_value[38:7], 0
);

	// input field unpacking
	logic [ACT_W-1:0]   action;
	logic [VALUE_W-1:0] value;
	logic [POS_W-1:0]   position;

	assign action   = s_tdata[ACT_W-1:0];
	assign value    = s_tdata[ACT_W+VALUE_W-1:ACT_W];
	assign position = s_tdata[IN_W-1:ACT_W+VALUE_W];

	// element count and output register
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	ple_status_t          out_status_q;
	logic [OUT_CNT_W-1:0] out_count_q;
	logic [REMOVED_W-1:0] out_removed_q;

	logic s_transfer;

	assign s_tready   = !out_valid_q || m_tready;
	assign s_transfer = s_tvalid && s_tready;

	// action decode
	logic             full;
	logic             empty;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic [CMP_W-1:0] at_x;
	logic             do_ins;
	logic             do_del;
	ple_status_t      status;

	assign full  = (cnt_q == CNT_W'(CAPACITY));
	assign empty = (cnt_q == '0);
	assign pos_x = CMP_W'(position);
	assign cnt_x = CMP_W'(cnt_q);

	always_comb begin
		at_x   = '0;
		do_ins = 1'b0;
		do_del = 1'b0;
		status = ST_OK;
		unique case (action)
			ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT: begin
				if (action == ACT_PUSH_BACK) begin
					at_x = cnt_x;
				end else if (action == ACT_INSERT) begin
					at_x = pos_x;
				end
				// fullness wins over a bad position
				if (full) begin
					status = ST_FULL;
				end else if (at_x > cnt_x) begin
					status = ST_RANGE;
				end else begin
					do_ins = 1'b1;
				end
			end
			ACT_POP_BACK, ACT_POP_FRONT, ACT_DELETE: begin
				if (action == ACT_POP_BACK) begin
					at_x = cnt_x - CMP_W'(1);
				end else if (action == ACT_DELETE) begin
					at_x = pos_x;
				end
				// emptiness wins over a bad position
				if (empty) begin
					status = ST_EMPTY;
				end else if (at_x >= cnt_x) begin
					status = ST_RANGE;
				end else begin
					do_del = 1'b1;
				end
			end
			default: begin
				// unknown action: no change, ok status
			end
		endcase
	end

	// control broadcast to the chain, only on a real transfer
	ple_ctrl_t ctrl;

	always_comb begin
		ctrl.open_gap  = s_transfer && do_ins;
		ctrl.close_gap = s_transfer && do_del;
		ctrl.at        = at_x[IDX_W-1:0];
		ctrl.fill      = DATA_WIDTH'($unsigned(value));
	end

	// cell chain
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_in;
		logic [DATA_WIDTH-1:0] right_in;

		if (i == 0) begin : g_first
			assign left_in = '0;
		end else begin : g_mid_l
			assign left_in = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_in = cell_data[i];
		end else begin : g_mid_r
			assign right_in = cell_data[i+1];
		end

		ple_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(i)),
			.ctrl       (ctrl),
			.left_data  (left_in),
			.right_data (right_in),
			.data       (cell_data[i]),
			.tap        (cell_tap[i])
		);
	end

	// removal bus: wired-or of the taps, only one cell is addressed
	logic [DATA_WIDTH-1:0] rem_or;

	always_comb begin
		rem_or = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			rem_or = rem_or | cell_tap[k];
		end
	end

	// next count
	logic [CNT_W-1:0] cnt_next;

	always_comb begin
		cnt_next = cnt_q;
		if (do_ins) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (do_del) begin
			cnt_next = cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_transfer) begin
				cnt_q       <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (s_transfer) begin
			out_status_q  <= status;
			out_count_q   <= cnt_next[OUT_CNT_W-1:0];
			out_removed_q <= do_del ? REMOVED_W'(rem_or) : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, out_removed_q, out_count_q, out_status_q};

endmodule

### hw/rtl/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker: port-level checks for the positional list engine
// watches both stream sides and the result fields over time
// ----------------------------------------------------------------------------
module ple_checker
	import ple_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [STATUS_W-1:0]  st;
	logic [OUT_CNT_W-1:0] cnt;
	logic [REMOVED_W-1:0] rem;

	assign st  = m_tdata[STATUS_W-1:0];
	assign cnt = m_tdata[STATUS_W+OUT_CNT_W-1:STATUS_W];
	assign rem = m_tdata[OUT_W-1:STATUS_W+OUT_CNT_W];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a waiting, stalled result blocks new input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted over a stalled result");

	// a transfer produces a result in the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after an input transfer");

	// refused actions take nothing out
	a_no_removal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st != ST_OK) |-> (rem == '0))
		else $error("removed value on a refused action");

	// an empty refusal reports an empty list
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == ST_EMPTY) |-> (cnt == '0))
		else $error("empty status with nonzero count");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
